// File: rtl/core/two_level_writeback_lru_cache_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-level cache core
// Shared property forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_WRITEBACK_LRU_CACHE_CORE_DEFINES_SVH
`define TWO_LEVEL_WRITEBACK_LRU_CACHE_CORE_DEFINES_SVH

// Same-cycle implication
`define TLWB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TLWB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/tlwb_pkg.sv
// ----------------------------------------------------------------------------
// tlwb_pkg
// Geometry, set row types and set update functions of the two-level cache.
// ----------------------------------------------------------------------------
package tlwb_pkg;

    localparam int ADDR_BITS    = 32;
    localparam int BLOCK_BYTES  = 32;
    localparam int OFFSET_BITS  = $clog2(BLOCK_BYTES);
    localparam int BLK_BITS     = ADDR_BITS - OFFSET_BITS;

    localparam int L1_SETS      = 64;
    localparam int L1_WAYS      = 4;
    localparam int L1_SET_BITS  = $clog2(L1_SETS);
    localparam int L1_WAY_BITS  = $clog2(L1_WAYS);
    localparam int L1_RANK_BITS = L1_WAY_BITS;
    localparam int L1_TAG_BITS  = BLK_BITS - L1_SET_BITS;

    localparam int L2_SETS      = 512;
    localparam int L2_WAYS      = 8;
    localparam int L2_SET_BITS  = $clog2(L2_SETS);
    localparam int L2_WAY_BITS  = $clog2(L2_WAYS);
    localparam int L2_RANK_BITS = L2_WAY_BITS;
    localparam int L2_TAG_BITS  = BLK_BITS - L2_SET_BITS;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_L1,
        ST_L2W,
        ST_L2RI,
        ST_L2R
    } state_t;

    typedef struct packed {
        logic [L1_TAG_BITS-1:0]  tag;
        logic                    valid;
        logic                    dirty;
        logic [L1_RANK_BITS-1:0] rank;
    } l1_way_t;

    typedef l1_way_t [L1_WAYS-1:0] l1_row_t;

    typedef struct packed {
        logic [L2_TAG_BITS-1:0]  tag;
        logic                    valid;
        logic                    dirty;
        logic [L2_RANK_BITS-1:0] rank;
    } l2_way_t;

    typedef l2_way_t [L2_WAYS-1:0] l2_row_t;

    typedef struct packed {
        l1_row_t                row;
        logic                   hit;
        logic                   wb;
        logic [L1_TAG_BITS-1:0] vtag;
    } l1_res_t;

    typedef struct packed {
        l2_row_t row;
        logic    miss;
        logic    wb;
    } l2_res_t;

    // Look up one first-level set, pick a victim on a miss, refresh recency
    function automatic l1_res_t l1_access(l1_row_t row, logic [L1_TAG_BITS-1:0] tag,
                                          logic wr);
        l1_res_t                 r;
        logic                    found;
        logic                    inv;
        logic [L1_WAY_BITS-1:0]  w;
        logic [L1_RANK_BITS:0]   old;
        r.row = row;
        found = 1'b0;
        inv   = 1'b0;
        w     = '0;
        for (int i = 0; i < L1_WAYS; i++) begin
            if (!found && row[i].valid && row[i].tag == tag) begin
                found = 1'b1;
                w     = L1_WAY_BITS'(i);
            end
        end
        if (!found) begin
            for (int i = 0; i < L1_WAYS; i++) begin
                if (!inv && !row[i].valid) begin
                    inv = 1'b1;
                    w   = L1_WAY_BITS'(i);
                end
            end
            if (!inv) begin
                w = '0;
                for (int i = 1; i < L1_WAYS; i++) begin
                    if (row[i].rank > row[w].rank) begin
                        w = L1_WAY_BITS'(i);
                    end
                end
            end
        end
        old = row[w].valid ? {1'b0, row[w].rank} : (L1_RANK_BITS+1)'(L1_WAYS);
        for (int v = 0; v < L1_WAYS; v++) begin
            if (L1_WAY_BITS'(v) != w && row[v].valid && {1'b0, row[v].rank} < old) begin
                r.row[v].rank = row[v].rank + L1_RANK_BITS'(1);
            end
        end
        r.row[w].rank = '0;
        r.hit  = found;
        r.wb   = !found && row[w].valid && row[w].dirty;
        r.vtag = row[w].tag;
        if (found) begin
            r.row[w].dirty = row[w].dirty | wr;
        end else begin
            r.row[w].tag   = tag;
            r.row[w].valid = 1'b1;
            r.row[w].dirty = wr;
        end
        return r;
    endfunction

    // Same access on one second-level set
    function automatic l2_res_t l2_access(l2_row_t row, logic [L2_TAG_BITS-1:0] tag,
                                          logic wr);
        l2_res_t                 r;
        logic                    found;
        logic                    inv;
        logic [L2_WAY_BITS-1:0]  w;
        logic [L2_RANK_BITS:0]   old;
        r.row = row;
        found = 1'b0;
        inv   = 1'b0;
        w     = '0;
        for (int i = 0; i < L2_WAYS; i++) begin
            if (!found && row[i].valid && row[i].tag == tag) begin
                found = 1'b1;
                w     = L2_WAY_BITS'(i);
            end
        end
        if (!found) begin
            for (int i = 0; i < L2_WAYS; i++) begin
                if (!inv && !row[i].valid) begin
                    inv = 1'b1;
                    w   = L2_WAY_BITS'(i);
                end
            end
            if (!inv) begin
                w = '0;
                for (int i = 1; i < L2_WAYS; i++) begin
                    if (row[i].rank > row[w].rank) begin
                        w = L2_WAY_BITS'(i);
                    end
                end
            end
        end
        old = row[w].valid ? {1'b0, row[w].rank} : (L2_RANK_BITS+1)'(L2_WAYS);
        for (int v = 0; v < L2_WAYS; v++) begin
            if (L2_WAY_BITS'(v) != w && row[v].valid && {1'b0, row[v].rank} < old) begin
                r.row[v].rank = row[v].rank + L2_RANK_BITS'(1);
            end
        end
        r.row[w].rank = '0;
        r.miss = !found;
        r.wb   = !found && row[w].valid && row[w].dirty;
        if (found) begin
            r.row[w].dirty = row[w].dirty | wr;
        end else begin
            r.row[w].tag   = tag;
            r.row[w].valid = 1'b1;
            r.row[w].dirty = wr;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/tlwb_ram.sv
// ----------------------------------------------------------------------------
// tlwb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tlwb_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then registered read (old data on collision)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/two_level_writeback_lru_cache_core.sv
// ----------------------------------------------------------------------------
// two_level_writeback_lru_cache_core
// Tag and state engine of a write-back, write-allocate L1 plus optional L2,
// both set associative with true LRU; set rows live in synchronous RAMs.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------
//  request   | start, busy          | operation, address
//  result    | done (one cycle)     | l1_hit .. memory_transfers
//  config    | cfg_we               | cfg_data (l2_present)
//
//  An L1 hit or a miss without L2 ends after the L1 state; a miss with a
//  clean victim adds the L2 read, a dirty victim the L2 victim write, a
//  read issue state and then the demand read. done shows back in idle, when
//  busy is already low. The L2 set RAM read port serves both L2 accesses.
//  After reset a clearing pass zeroes every set row of both RAMs; busy is high.
//  Results cannot be stalled; busy drops in the cycle done is shown.
// ----------------------------------------------------------------------------
`include "two_level_writeback_lru_cache_core_defines.svh"

module two_level_writeback_lru_cache_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [31:0] address,
    input  logic        cfg_we,
    input  logic        cfg_data,
    output logic        done,
    output logic        l1_hit,
    output logic        l1_writeback,
    output logic [31:0] victim_address,
    output logic        l2_read_miss,
    output logic        l2_write_miss,
    output logic [1:0]  l2_writebacks,
    output logic [2:0]  memory_transfers
);

    localparam int OB  = tlwb_pkg::OFFSET_BITS;
    localparam int S1  = tlwb_pkg::L1_SET_BITS;
    localparam int S2  = tlwb_pkg::L2_SET_BITS;
    localparam int BB  = tlwb_pkg::BLK_BITS;
    localparam int ADDR_TOP = tlwb_pkg::ADDR_BITS - 1;

    tlwb_pkg::state_t state_reg, state_next;

    logic [S2-1:0]       clr_reg;
    logic                l2p_reg;
    logic                op_reg;
    logic [BB-1:0]       blk_reg;
    logic [BB-1:0]       vblk_reg;
    logic                l2use_reg;
    logic                hit_reg;
    logic                wb_reg;
    logic                wmiss_reg;
    logic                rmiss_reg;
    logic [1:0]          l2wbs_reg;
    logic                done_reg;

    logic                 l1_we;
    logic [S1-1:0]        l1_waddr;
    tlwb_pkg::l1_row_t    l1_wdata;
    tlwb_pkg::l1_row_t    l1_rdata;
    logic                 l2_we;
    logic [S2-1:0]        l2_waddr;
    tlwb_pkg::l2_row_t    l2_wdata;
    logic [S2-1:0]        l2_raddr;
    tlwb_pkg::l2_row_t    l2_rdata;

    tlwb_pkg::l1_res_t    l1_res;
    tlwb_pkg::l2_res_t    l2_res;
    logic [BB-1:0]        l2_blk;
    logic [BB-1:0]        vblk;

    tlwb_ram #(.DEPTH(tlwb_pkg::L1_SETS), .WIDTH($bits(tlwb_pkg::l1_row_t))) u_l1_ram (
        .clk   (clk),
        .we    (l1_we),
        .waddr (l1_waddr),
        .wdata (l1_wdata),
        .raddr (address[OB +: S1]),
        .rdata (l1_rdata)
    );

    tlwb_ram #(.DEPTH(tlwb_pkg::L2_SETS), .WIDTH($bits(tlwb_pkg::l2_row_t))) u_l2_ram (
        .clk   (clk),
        .we    (l2_we),
        .waddr (l2_waddr),
        .wdata (l2_wdata),
        .raddr (l2_raddr),
        .rdata (l2_rdata)
    );

    // Set updates
    assign l1_res = tlwb_pkg::l1_access(l1_rdata, blk_reg[BB-1:S1], op_reg);
    assign vblk   = {l1_res.vtag, blk_reg[S1-1:0]};
    assign l2_blk = (state_reg == tlwb_pkg::ST_L2W) ? vblk_reg : blk_reg;
    assign l2_res = tlwb_pkg::l2_access(l2_rdata, l2_blk[BB-1:S2],
                                        state_reg == tlwb_pkg::ST_L2W);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tlwb_pkg::ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = tlwb_pkg::ST_IDLE;
                end
            end
            tlwb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = tlwb_pkg::ST_L1;
                end
            end
            tlwb_pkg::ST_L1:
            begin
                if (l1_res.hit || !l2p_reg)
                begin
                    state_next = tlwb_pkg::ST_IDLE;
                end
                else if (l1_res.wb)
                begin
                    state_next = tlwb_pkg::ST_L2W;
                end
                else
                begin
                    state_next = tlwb_pkg::ST_L2R;
                end
            end
            tlwb_pkg::ST_L2W:  state_next = tlwb_pkg::ST_L2RI;
            tlwb_pkg::ST_L2RI: state_next = tlwb_pkg::ST_L2R;
            tlwb_pkg::ST_L2R:  state_next = tlwb_pkg::ST_IDLE;
            default:           state_next = tlwb_pkg::ST_IDLE;
        endcase
    end

    // RAM controls
    always_comb
    begin
        l1_we    = 1'b0;
        l1_waddr = blk_reg[S1-1:0];
        l1_wdata = l1_res.row;
        l2_we    = 1'b0;
        l2_waddr = l2_blk[S2-1:0];
        l2_wdata = l2_res.row;
        l2_raddr = blk_reg[S2-1:0];
        case (state_reg)
            tlwb_pkg::ST_CLEAR:
            begin
                l1_we    = (clr_reg[S2-1:S1] == '0);
                l1_waddr = clr_reg[S1-1:0];
                l1_wdata = '0;
                l2_we    = 1'b1;
                l2_waddr = clr_reg;
                l2_wdata = '0;
            end
            tlwb_pkg::ST_L1:
            begin
                l1_we    = 1'b1;
                l2_raddr = l1_res.wb ? vblk[S2-1:0] : blk_reg[S2-1:0];
            end
            tlwb_pkg::ST_L2W: l2_we = 1'b1;
            tlwb_pkg::ST_L2R: l2_we = 1'b1;
            default:
            begin
                l2_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlwb_pkg::ST_CLEAR;
            clr_reg   <= '0;
            l2p_reg   <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tlwb_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + S2'(1);
            end
            if (cfg_we)
            begin
                l2p_reg <= cfg_data;
            end
            done_reg <= (state_reg != tlwb_pkg::ST_IDLE) && (state_reg != tlwb_pkg::ST_CLEAR)
                        && (state_next == tlwb_pkg::ST_IDLE);
        end
    end

    // Request and result accumulators
    always_ff @(posedge clk)
    begin
        case (state_reg)
            tlwb_pkg::ST_IDLE:
            begin
                op_reg  <= operation;
                blk_reg <= address[ADDR_TOP:OB];
            end
            tlwb_pkg::ST_L1:
            begin
                hit_reg   <= l1_res.hit;
                wb_reg    <= l1_res.wb;
                vblk_reg  <= vblk;
                l2use_reg <= l2p_reg;
                wmiss_reg <= 1'b0;
                rmiss_reg <= 1'b0;
                l2wbs_reg <= '0;
            end
            tlwb_pkg::ST_L2W:
            begin
                wmiss_reg <= l2_res.miss;
                l2wbs_reg <= {1'b0, l2_res.wb};
            end
            tlwb_pkg::ST_L2R:
            begin
                rmiss_reg <= l2_res.miss;
                l2wbs_reg <= l2wbs_reg + {1'b0, l2_res.wb};
            end
            default:
            begin
                hit_reg <= hit_reg;
            end
        endcase
    end

    // Outputs
    assign busy             = (state_reg != tlwb_pkg::ST_IDLE);
    assign done             = done_reg;
    assign l1_hit           = hit_reg;
    assign l1_writeback     = wb_reg;
    assign victim_address   = wb_reg ? {vblk_reg, OB'(0)} : '0;
    assign l2_read_miss     = rmiss_reg;
    assign l2_write_miss    = wmiss_reg;
    assign l2_writebacks    = l2wbs_reg;
    assign memory_transfers = hit_reg   ? 3'd0 :
                              l2use_reg ? 3'(rmiss_reg) + 3'(wmiss_reg) + 3'(l2wbs_reg) :
                                          3'd1 + 3'(wb_reg);

    `TLWB_ASSERT_NOW(a_hit_quiet, done && l1_hit, memory_transfers == 3'd0 && !l1_writeback, "L1 hit caused traffic")
    `TLWB_ASSERT_NOW(a_victim_zero, done && !l1_writeback, victim_address == '0, "victim address without writeback")
    `TLWB_ASSERT_NOW(a_l2wbs_bound, done && !l2_write_miss, l2_writebacks != 2'd2, "too many L2 writebacks")
    `TLWB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but not busy")

endmodule
